// File: sv/tpb_pkg.sv
package tpb_pkg;

   localparam int NUM_TIMERS  = 16;
   localparam int MAX_RESULTS = 16;
   // Slot index inside the chain; at least as wide as the slot field.
   localparam int IDX_W       = (NUM_TIMERS > 16) ? $clog2(NUM_TIMERS) : 4;
   localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

   localparam logic [2:0] ACT_CREATE  = 3'd0;
   localparam logic [2:0] ACT_TICK    = 3'd1;
   localparam logic [2:0] ACT_RESTART = 3'd2;
   localparam logic [2:0] ACT_REMOVE  = 3'd3;
   localparam logic [2:0] ACT_CLEAR   = 3'd4;

   localparam logic [2:0] KIND_CREATED = 3'd0;
   localparam logic [2:0] KIND_ZERO    = 3'd1;
   localparam logic [2:0] KIND_FULL    = 3'd2;
   localparam logic [2:0] KIND_EXPIRED = 3'd3;
   localparam logic [2:0] KIND_DONE    = 3'd4;

   typedef struct packed {
      logic [2:0]  action;
      logic [3:0]  slot;
      logic [31:0] timeout;
      logic        repeat_on;
   } req_type;

   typedef struct packed {
      logic [2:0] result_kind;
      logic [3:0] slot_id;
      logic       last_result;
   } rsp_type;

   // Command as it travels from cell to cell.
   typedef struct packed {
      logic [2:0]       action;
      logic [3:0]       slot;
      logic [31:0]      timeout;
      logic             repeat_on;
      logic             open;
      logic [IDX_W-1:0] idx;
   } link_type;

   // Result raised by the cell that currently holds the command.
   typedef struct packed {
      logic             emit;
      logic [2:0]       kind;
      logic [IDX_W-1:0] idx;
   } event_type;

endpackage

// File: sv/tpb_cell.sv
module tpb_cell (
   input  logic               clock,
   input  logic               reset,
   input  logic               adv,
   input  logic               tok_in,
   input  tpb_pkg::link_type  link_in,
   output logic               tok_out,
   output tpb_pkg::link_type  link_out,
   output tpb_pkg::event_type ev_out
);
   import tpb_pkg::*;

   logic        busy_ff, busy_in;
   logic        rep_ff, rep_in;
   logic [31:0] rem_ff, rem_in;
   logic [31:0] rel_ff, rel_in;
   logic [31:0] dec;
   logic        tok_ff;
   link_type    link_ff, link_in_nx;
   logic        match;

   assign match = (link_in.slot == link_in.idx[3:0]) &&
                  (IDX_W'(link_in.slot) == link_in.idx);
   assign dec   = rem_ff - 32'd1;

   always_comb begin
      busy_in        = busy_ff;
      rep_in         = rep_ff;
      rem_in         = rem_ff;
      rel_in         = rel_ff;
      link_in_nx     = link_in;
      link_in_nx.idx = link_in.idx + IDX_W'(1);
      ev_out         = '0;
      if (tok_in) begin
         // Only the cell holding the command may drive the shared event bus.
         ev_out.idx = link_in.idx;
         case (link_in.action)
            ACT_CREATE: begin
               // The first free cell that sees an open request claims it.
               if (link_in.open && !busy_ff) begin
                  busy_in         = 1'b1;
                  rep_in          = link_in.repeat_on;
                  rem_in          = link_in.timeout;
                  rel_in          = link_in.timeout;
                  link_in_nx.open = 1'b0;
                  ev_out.emit     = 1'b1;
                  ev_out.kind     = KIND_CREATED;
               end
            end
            ACT_TICK: begin
               if (busy_ff && (rem_ff != 32'd0)) begin
                  if (dec == 32'd0) begin
                     ev_out.emit = 1'b1;
                     ev_out.kind = KIND_EXPIRED;
                     rem_in      = rep_ff ? rel_ff : 32'd0;
                  end else begin
                     rem_in = dec;
                  end
               end
            end
            ACT_RESTART: begin
               if (match && busy_ff) begin
                  rem_in = rel_ff;
               end
            end
            ACT_REMOVE: begin
               if (match) begin
                  busy_in = 1'b0;
               end
            end
            ACT_CLEAR: begin
               busy_in = 1'b0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         tok_ff  <= 1'b0;
      end else if (adv) begin
         busy_ff <= busy_in;
         tok_ff  <= tok_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rep_ff  <= rep_in;
         rem_ff  <= rem_in;
         rel_ff  <= rel_in;
         link_ff <= link_in_nx;
      end
   end

   assign tok_out  = tok_ff;
   assign link_out = link_ff;

endmodule

// File: sv/timer_pool_bank_core.sv
// Bank of countdown timers. Each command walks a row of timer cells, one slot per
// cycle, starting at slot 0; every cell holds one timer and acts on the command as it
// passes. req_stall stays high from acceptance until the final result of an item
// has been produced, so the block takes no new item while one is walking the row.
// Results of a tick (one per expiring slot, ascending) leave one per cycle; rsp_stall
// freezes the whole row.
module timer_pool_bank_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  tpb_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output tpb_pkg::rsp_type rsp_data
);
   import tpb_pkg::*;

   logic             adv;
   logic             accept;
   logic             busy_ff, busy_in;
   logic             start_tok_ff, start_tok_in;
   link_type         start_link_ff;
   logic             tok_w  [0:NUM_TIMERS];
   link_type         link_w [0:NUM_TIMERS];
   event_type        ev_w   [0:NUM_TIMERS-1];
   event_type        ev_all;
   logic             held_v_ff, held_v_in;
   rsp_type          held_ff, held_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             push;
   rsp_type          push_data;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff, rsp_data_in;
   logic [2:0]       fallback_kind;
   logic [NUM_TIMERS:0] tok_vec;

   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign accept    = req_valid && !busy_ff;
   assign req_stall = busy_ff;

   assign tok_w[0]  = start_tok_ff;
   assign link_w[0] = start_link_ff;

   for (genvar i = 0; i < NUM_TIMERS; i++) begin : g_cell
      tpb_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .adv      (adv),
         .tok_in   (tok_w[i]),
         .link_in  (link_w[i]),
         .tok_out  (tok_w[i+1]),
         .link_out (link_w[i+1]),
         .ev_out   (ev_w[i])
      );
   end

   always_comb begin
      ev_all = '0;
      for (int i = 0; i < NUM_TIMERS; i++) begin
         ev_all = ev_all | ev_w[i];
      end
   end

   always_comb begin
      for (int i = 0; i <= NUM_TIMERS; i++) begin
         tok_vec[i] = tok_w[i];
      end
   end

   // The start register keeps the command after it leaves, for the closing result.
   always_comb begin
      if (start_link_ff.action == ACT_CREATE) begin
         fallback_kind = start_link_ff.open ? KIND_FULL : KIND_ZERO;
      end else begin
         fallback_kind = KIND_DONE;
      end
   end

   // One result is held back so that the final one can be marked on the closing beat.
   always_comb begin
      busy_in   = busy_ff;
      held_v_in = held_v_ff;
      held_in   = held_ff;
      cnt_in    = cnt_ff;
      push      = 1'b0;
      push_data = held_ff;
      push_data.last_result = 1'b0;
      if (adv) begin
         if (tok_w[NUM_TIMERS]) begin
            push      = 1'b1;
            busy_in   = 1'b0;
            held_v_in = 1'b0;
            cnt_in    = '0;
            if (held_v_ff) begin
               push_data.last_result = 1'b1;
            end else begin
               push_data.result_kind = fallback_kind;
               push_data.slot_id     = 4'd0;
               push_data.last_result = 1'b1;
            end
         end else if (ev_all.emit && (cnt_ff < CNT_W'(MAX_RESULTS))) begin
            push                = held_v_ff;
            held_v_in           = 1'b1;
            held_in.result_kind = ev_all.kind;
            held_in.slot_id     = ev_all.idx[3:0];
            held_in.last_result = 1'b0;
            cnt_in              = cnt_ff + CNT_W'(1);
         end
      end
      if (accept) begin
         busy_in = 1'b1;
      end
   end

   always_comb begin
      if (accept) begin
         start_tok_in = 1'b1;
      end else if (adv) begin
         start_tok_in = 1'b0;
      end else begin
         start_tok_in = start_tok_ff;
      end
      rsp_valid_in = adv ? push : rsp_valid_ff;
      rsp_data_in  = (adv && push) ? push_data : rsp_data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         start_tok_ff <= 1'b0;
         held_v_ff    <= 1'b0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         start_tok_ff <= start_tok_in;
         held_v_ff    <= held_v_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      held_ff     <= held_in;
      rsp_data_ff <= rsp_data_in;
      if (accept) begin
         start_link_ff.action    <= req_data.action;
         start_link_ff.slot      <= req_data.slot;
         start_link_ff.timeout   <= req_data.timeout;
         start_link_ff.repeat_on <= req_data.repeat_on;
         start_link_ff.open      <= (req_data.timeout != 32'd0);
         start_link_ff.idx       <= '0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTH
   a_one_command: assert property (@(posedge clock) disable iff (reset)
      $onehot0(tok_vec))
      else $error("more than one command in the cell row");

   a_tok_needs_busy: assert property (@(posedge clock) disable iff (reset)
      (tok_vec != '0) |-> busy_ff)
      else $error("command in the cell row while the block is idle");

   a_held_needs_busy: assert property (@(posedge clock) disable iff (reset)
      held_v_ff |-> busy_ff)
      else $error("held result outside a command");

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(MAX_RESULTS))
      else $error("result count beyond its limit");

   a_close_frees: assert property (@(posedge clock) disable iff (reset)
      (tok_w[NUM_TIMERS] && adv) |=> (!busy_ff && !held_v_ff && rsp_valid_ff))
      else $error("closing beat did not finish the command");
`endif

endmodule
